/* src/hro_pkg.sv */
// ----------------------------------------------------------------------------
// hro_pkg
// Shared types, widths and the arctangent table for the heading-relative
// offset pipeline.
// ----------------------------------------------------------------------------
package hro_pkg;

  // Coordinate and angle formats
  localparam int COORD_W     = 24;
  localparam int ANGLE_W     = 16;
  localparam int ANGLE_SHIFT = 16;   // widen angle to 2^32 per turn

  // CORDIC datapath
  localparam int CORDIC_GUARD      = 16;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ANGLE_STEPS       = 24;
  localparam int CW                = 44;  // rotated vector width
  localparam int RW                = 34;  // angle residue width

  // Gain prescale: K = GAIN_Q30 / 2^30
  localparam int GAIN_W     = 31;
  localparam int GAIN_Q30   = 652032874;
  localparam int PW         = COORD_W + GAIN_W;
  localparam int PRE_SHIFT  = 30 - CORDIC_GUARD;
  localparam int PRE_ROUND  = 1 << (PRE_SHIFT - 1);

  // Final sum width before clamping
  localparam int SW        = 30;
  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;

  // atan(2^-i) in 2^32-per-turn units
  localparam logic [31:0] ATAN_TURN32 [ANGLE_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // Input item
  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [ANGLE_W-1:0] heading;
    logic signed [COORD_W-1:0] offset_right;
    logic signed [COORD_W-1:0] offset_up;
    logic signed [COORD_W-1:0] offset_forward;
  } item_t;

  // Result item
  typedef struct packed {
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic signed [COORD_W-1:0] new_z;
    logic                      saturated;
  } result_t;

  // Rotation state carried through the CORDIC stages
  typedef struct packed {
    logic signed [CW-1:0]      a;
    logic signed [CW-1:0]      b;
    logic signed [RW-1:0]      res;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W-1:0] u;
  } rot_t;

endpackage

/* src/hro_prescale.sv */
// ----------------------------------------------------------------------------
// hro_prescale
// Two stages: multiply the right and forward offsets by the CORDIC gain, then round to
// the guard format, fold the quadrant and widen the angle.
// ----------------------------------------------------------------------------
module hro_prescale (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  hro_pkg::item_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output hro_pkg::rot_t  dn_data
);
  import hro_pkg::*;

  localparam logic signed [GAIN_W-1:0] GAIN = GAIN_W'(GAIN_Q30);

  logic                      va;
  logic signed [PW-1:0]      pa;
  logic signed [PW-1:0]      pb;
  logic signed [ANGLE_W-1:0] ang;
  logic signed [COORD_W-1:0] px, py, pz, u;
  logic                      ready_a;
  logic                      ready_b;
  rot_t                      rot_next;

  assign ready_b  = !dn_valid || dn_ready;
  assign ready_a  = !va || ready_b;
  assign up_ready = ready_a;

  // Stage A: gain multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ready_a) begin
      va <= up_valid;
    end
    if (ready_a && up_valid) begin
      pa  <= up_data.offset_right * GAIN;
      pb  <= up_data.offset_forward * GAIN;
      ang <= up_data.heading;
      px  <= up_data.pos_x;
      py  <= up_data.pos_y;
      pz  <= up_data.pos_z;
      u   <= up_data.offset_up;
    end
  end

  // Stage B: round to guard format, fold quadrant, widen angle
  always_comb begin
    logic signed [PW-1:0]      sa;
    logic signed [PW-1:0]      sb;
    logic signed [ANGLE_W-1:0] tf;
    logic                      fold;
    sa   = (pa + PW'(PRE_ROUND)) >>> PRE_SHIFT;
    sb   = (pb + PW'(PRE_ROUND)) >>> PRE_SHIFT;
    fold = ang[ANGLE_W-1] ^ ang[ANGLE_W-2];
    tf   = fold ? {~ang[ANGLE_W-1], ang[ANGLE_W-2:0]} : ang;
    rot_next.a   = fold ? -CW'(sa) : CW'(sa);
    rot_next.b   = fold ? -CW'(sb) : CW'(sb);
    rot_next.res = RW'(tf) <<< ANGLE_SHIFT;
    rot_next.px  = px;
    rot_next.py  = py;
    rot_next.pz  = pz;
    rot_next.u   = u;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (ready_b) begin
      dn_valid <= va;
    end
    if (ready_b && va) begin
      dn_data <= rot_next;
    end
  end

endmodule

/* src/hro_cordic_stage.sv */
// ----------------------------------------------------------------------------
// hro_cordic_stage
// One registered CORDIC rotation-mode iteration with a fixed shift.
// ----------------------------------------------------------------------------
module hro_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  hro_pkg::rot_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output hro_pkg::rot_t dn_data
);
  import hro_pkg::*;

  localparam logic signed [RW-1:0] ANGLE = RW'(ATAN_TURN32[STEP]);

  rot_t rot_next;

  assign up_ready = !dn_valid || dn_ready;

  // Rotate toward zero residue
  always_comb begin
    logic signed [CW-1:0] sa;
    logic signed [CW-1:0] sb;
    sa       = up_data.a >>> STEP;
    sb       = up_data.b >>> STEP;
    rot_next = up_data;
    if (!up_data.res[RW-1]) begin
      rot_next.a   = up_data.a - sb;
      rot_next.b   = up_data.b + sa;
      rot_next.res = up_data.res - ANGLE;
    end else begin
      rot_next.a   = up_data.a + sb;
      rot_next.b   = up_data.b - sa;
      rot_next.res = up_data.res + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_data <= rot_next;
    end
  end

endmodule

/* src/hro_finish.sv */
// ----------------------------------------------------------------------------
// hro_finish
// Round the rotated offset to coordinate format, add it to the position and
// clamp each sum; registers the result item.
// ----------------------------------------------------------------------------
module hro_finish (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  hro_pkg::rot_t    up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output hro_pkg::result_t dn_data
);
  import hro_pkg::*;

  localparam logic signed [SW-1:0] SUM_MAX = SW'(COORD_MAX);
  localparam logic signed [SW-1:0] SUM_MIN = SW'(COORD_MIN);

  result_t res_next;

  assign up_ready = !dn_valid || dn_ready;

  // Clamp one sum to the coordinate range
  function automatic logic signed [COORD_W-1:0] clamp(input logic signed [SW-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SUM_MAX) begin
      r = COORD_W'(SUM_MAX);
    end else if (v < SUM_MIN) begin
      r = COORD_W'(SUM_MIN);
    end else begin
      r = COORD_W'(v);
    end
    return r;
  endfunction

  function automatic logic out_of_range(input logic signed [SW-1:0] v);
    return (v > SUM_MAX) || (v < SUM_MIN);
  endfunction

  always_comb begin
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] rz;
    logic signed [SW-1:0] dx;
    logic signed [SW-1:0] dz;
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] sz;
    rx = (-up_data.a + CW'(1 << (CORDIC_GUARD - 1))) >>> CORDIC_GUARD;
    rz = (up_data.b + CW'(1 << (CORDIC_GUARD - 1))) >>> CORDIC_GUARD;
    dx = SW'(rx);
    dz = SW'(rz);
    sx = SW'(up_data.px) + dx;
    sy = SW'(up_data.py) + SW'(up_data.u);
    sz = SW'(up_data.pz) + dz;
    res_next.new_x     = clamp(sx);
    res_next.new_y     = clamp(sy);
    res_next.new_z     = clamp(sz);
    res_next.saturated = out_of_range(sx) || out_of_range(sy) || out_of_range(sz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_data <= res_next;
    end
  end

endmodule

/* src/heading_relative_offset.sv */
// Path: item accept to result runs through the prescale stages, each CORDIC stage and the finish stage.
// Throughput: one item per cycle while results are taken, set by one CORDIC iteration per stage.
// Empty stages keep filling while a result waits; ready ripples back through
// the stage valid bits.
// Reset: synchronous, clears every stage valid bit; no state beyond them.
// ----------------------------------------------------------------------------
// heading_relative_offset
// Moves a position by an offset rotated by a heading, through a gain
// prescale, an unrolled CORDIC pipeline and a saturating adder stage.
// ----------------------------------------------------------------------------
module heading_relative_offset #(
  parameter int CORDIC_ITERATIONS = hro_pkg::CORDIC_ITERATIONS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  hro_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output hro_pkg::result_t result
);
  import hro_pkg::*;

  localparam int ITER = (CORDIC_ITERATIONS < ANGLE_STEPS) ? CORDIC_ITERATIONS : ANGLE_STEPS;

  logic stage_valid [ITER+1];
  logic stage_ready [ITER+1];
  rot_t stage_data  [ITER+1];

  // Gain prescale and quadrant fold
  hro_prescale u_prescale (
    .clk      (clk),
    .rst      (rst),
    .up_valid (item_valid),
    .up_ready (item_ready),
    .up_data  (item),
    .dn_valid (stage_valid[0]),
    .dn_ready (stage_ready[0]),
    .dn_data  (stage_data[0])
  );

  // Unrolled CORDIC iterations
  for (genvar i = 0; i < ITER; i++) begin : g_iter
    hro_cordic_stage #(
      .STEP (i)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stage_valid[i]),
      .up_ready (stage_ready[i]),
      .up_data  (stage_data[i]),
      .dn_valid (stage_valid[i+1]),
      .dn_ready (stage_ready[i+1]),
      .dn_data  (stage_data[i+1])
    );
  end

  // Round, add and clamp
  hro_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .up_valid (stage_valid[ITER]),
    .up_ready (stage_ready[ITER]),
    .up_data  (stage_data[ITER]),
    .dn_valid (result_valid),
    .dn_ready (result_ready),
    .dn_data  (result)
  );

`ifndef SYNTHESIS
  // An empty output stage frees the whole chain
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("item_ready low with empty output stage");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !result_valid)
    else $error("result valid right after reset");

  // A flagged clamp leaves some coordinate at a range limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.saturated) |->
      (result.new_x == COORD_W'(COORD_MAX)) || (result.new_x == COORD_W'(COORD_MIN)) ||
      (result.new_y == COORD_W'(COORD_MAX)) || (result.new_y == COORD_W'(COORD_MIN)) ||
      (result.new_z == COORD_W'(COORD_MAX)) || (result.new_z == COORD_W'(COORD_MIN)))
    else $error("saturated set with no coordinate at a limit");
`endif

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for heading_relative_offset. A short table of directed
// moves (zero offsets, coordinate extremes, quadrant edges, saturation) runs
// first, then about two thousand random moves. Every result is compared field
// by field with a bit-exact model of the gain prescale, quadrant fold, CORDIC
// rotation and saturating sum, while both handshakes idle at random outside a calm stretch.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hro_pkg::*;

  localparam int RANDOM_MOVES = 2000;
  localparam int IDLE_PCT     = 23;
  localparam int STEPS        = (hro_pkg::CORDIC_ITERATIONS < 24) ?
                                hro_pkg::CORDIC_ITERATIONS : 24;
  localparam int LATENCY      = STEPS + 3;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PRINT_LIMIT  = 200;

  localparam logic signed [23:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] C_MIN = 24'sh800000;

  localparam longint GAIN      = 64'sd652032874;
  localparam longint PRE_ROUND = 64'sd8192;    // half of 2^14
  localparam longint OUT_ROUND = 64'sd32768;   // half of 2^16

  // atan(2^-i), 2^32 per turn
  localparam longint ARC [24] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
    64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
  };

  typedef struct {
    item_t   stim;
    bit      fixed;
    result_t want;
  } drill_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  result_t landing_q [$];
  drill_t  drill_q [$];
  int      fault_count  = 0;
  int      results_seen = 0;
  int      quiet_cycles = 0;
  bit      calm         = 1'b0;

  heading_relative_offset i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic flag_fault(input string msg);
    if (fault_count < PRINT_LIMIT) $display("MISMATCH: %s", msg);
    fault_count++;
  endtask

  // Multiply by the CORDIC gain, keep 16 guard fraction bits
  function automatic longint gain_scale(input longint v);
    return (v * GAIN + PRE_ROUND) >>> 14;
  endfunction

  function automatic longint clamp_coord(input longint v, inout bit hit);
    if (v > longint'(C_MAX)) begin
      hit = 1'b1;
      return longint'(C_MAX);
    end
    if (v < longint'(C_MIN)) begin
      hit = 1'b1;
      return longint'(C_MIN);
    end
    return v;
  endfunction

  // Predict the moved position for one item
  function automatic result_t shift_position(input item_t it);
    longint      a, b, res, sa, sb, dx, dz, nx, ny, nz;
    logic [15:0] ang;
    bit          hit;
    result_t     r;
    hit = 1'b0;
    a   = gain_scale(longint'($signed(it.offset_right)));
    b   = gain_scale(longint'($signed(it.offset_forward)));
    ang = it.heading;
    // fold the second and third quadrants by half a turn
    if (ang[15:14] == 2'b01 || ang[15:14] == 2'b10) begin
      a       = -a;
      b       = -b;
      ang[15] = ~ang[15];
    end
    res = longint'($signed(ang)) * 65536;
    for (int i = 0; i < STEPS; i++) begin
      sa = a >>> i;
      sb = b >>> i;
      if (res >= 0) begin
        a   = a - sb;
        b   = b + sa;
        res = res - ARC[i];
      end else begin
        a   = a + sb;
        b   = b - sa;
        res = res + ARC[i];
      end
    end
    dx = (-a + OUT_ROUND) >>> 16;
    dz = (b + OUT_ROUND) >>> 16;
    nx = clamp_coord(longint'($signed(it.pos_x)) + dx, hit);
    ny = clamp_coord(longint'($signed(it.pos_y)) + longint'($signed(it.offset_up)), hit);
    nz = clamp_coord(longint'($signed(it.pos_z)) + dz, hit);
    r.new_x     = nx[23:0];
    r.new_y     = ny[23:0];
    r.new_z     = nz[23:0];
    r.saturated = hit;
    return r;
  endfunction

  function automatic item_t pack_item(
    input logic signed [23:0] px, py, pz,
    input logic signed [15:0] h,
    input logic signed [23:0] r, u, f
  );
    item_t it;
    it.pos_x          = px;
    it.pos_y          = py;
    it.pos_z          = pz;
    it.heading        = h;
    it.offset_right   = r;
    it.offset_up      = u;
    it.offset_forward = f;
    return it;
  endfunction

  function automatic result_t pack_result(
    input logic signed [23:0] x, y, z,
    input logic s
  );
    result_t r;
    r.new_x     = x;
    r.new_y     = y;
    r.new_z     = z;
    r.saturated = s;
    return r;
  endfunction

  task automatic add_row(input item_t stim, input bit fixed, input result_t want);
    drill_t d;
    d.stim  = stim;
    d.fixed = fixed;
    d.want  = want;
    drill_q.push_back(d);
  endtask

  // Spread coordinates over full range, small values and both extremes
  function automatic logic [23:0] pick_coord();
    logic [23:0] v;
    case ($urandom_range(9))
      5, 6:    v = 24'($urandom_range(4095)) - 24'd2048;
      7:       v = 24'h7FFFFF - 24'($urandom_range(255));
      8:       v = 24'h800000 + 24'($urandom_range(255));
      9:       v = 24'($urandom_range(3));
      default: v = 24'($urandom);
    endcase
    return v;
  endfunction

  // Full-range angles, plus angles close to the quadrant edges
  function automatic logic [15:0] pick_heading();
    logic [15:0] h;
    if ($urandom_range(3) == 0)
      h = 16'($urandom_range(3)) * 16'h4000 + 16'($urandom_range(4)) - 16'd2;
    else
      h = 16'($urandom);
    return h;
  endfunction

  // Drive one item and hold it until accepted, then log its prediction
  task automatic send_move(input item_t it, input result_t want);
    while ($urandom_range(99) < (calm ? 0 : IDLE_PCT)) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    landing_q.push_back(want);
  endtask

  // Directed table: typed results where they are obvious, model elsewhere
  task automatic fill_drill();
    // zero offsets leave the position alone
    add_row(pack_item(0, 0, 0, 0, 0, 0, 0), 1'b1, pack_result(0, 0, 0, 1'b0));
    add_row(pack_item(C_MAX, C_MAX, C_MAX, 16'sh1234, 0, 0, 0), 1'b1,
            pack_result(C_MAX, C_MAX, C_MAX, 1'b0));
    add_row(pack_item(C_MIN, C_MIN, C_MIN, -16'sd32768, 0, 0, 0), 1'b1,
            pack_result(C_MIN, C_MIN, C_MIN, 1'b0));
    // height clamps at both ends, and a sum that just fits
    add_row(pack_item(0, C_MAX, 0, 0, 0, C_MAX, 0), 1'b1, pack_result(0, C_MAX, 0, 1'b1));
    add_row(pack_item(0, C_MIN, 0, 0, 0, C_MIN, 0), 1'b1, pack_result(0, C_MIN, 0, 1'b1));
    add_row(pack_item(0, C_MAX, 0, 0, 0, C_MIN, 0), 1'b1, pack_result(0, -24'sd1, 0, 1'b0));
    // offsets of 256 and 512 around the quadrant edges and the half turn
    add_row(pack_item(0, 0, 0, 0, 256, 0, 0), 1'b0, '0);
    add_row(pack_item(0, 0, 0, 0, 0, 0, 256), 1'b0, '0);
    add_row(pack_item(100, 5, -100, 16'sh4000, 256, 7, 512), 1'b0, '0);
    add_row(pack_item(100, 5, -100, -16'sd16384, 256, 7, 512), 1'b0, '0);
    add_row(pack_item(100, 5, -100, -16'sd32768, 256, 7, 512), 1'b0, '0);
    add_row(pack_item(100, 5, -100, 16'sh3FFF, 256, 7, 512), 1'b0, '0);
    add_row(pack_item(100, 5, -100, 16'sh7FFF, 256, 7, 512), 1'b0, '0);
    add_row(pack_item(100, 5, -100, -16'sd16385, 256, 7, 512), 1'b0, '0);
    add_row(pack_item(100, 5, -100, -16'sd32767, 256, 7, 512), 1'b0, '0);
    add_row(pack_item(0, 0, 0, 16'sh0001, C_MAX, 0, 0), 1'b0, '0);
    // extreme offsets, rotated and saturating
    add_row(pack_item(0, 0, 0, 16'sh2000, C_MAX, 0, C_MAX), 1'b0, '0);
    add_row(pack_item(0, 0, 0, 16'sh2000, C_MIN, 0, C_MIN), 1'b0, '0);
    add_row(pack_item(C_MAX, 0, 0, 0, C_MIN, 0, 0), 1'b0, '0);
    add_row(pack_item(0, 0, C_MIN, 0, 0, 0, C_MIN), 1'b0, '0);
    add_row(pack_item(0, 0, C_MAX, -16'sd32768, 0, 0, C_MAX), 1'b0, '0);
    add_row(pack_item(C_MIN, C_MAX, C_MAX, 16'sh6000, C_MAX, C_MAX, C_MIN), 1'b0, '0);
  endtask

  // Stimulus and end of run
  initial begin
    item_t it;
    fill_drill();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (drill_q[k])
      send_move(drill_q[k].stim,
                drill_q[k].fixed ? drill_q[k].want : shift_position(drill_q[k].stim));
    for (int n = 0; n < RANDOM_MOVES; n++) begin
      calm = (n >= 800 && n < 1100);
      it.pos_x          = pick_coord();
      it.pos_y          = pick_coord();
      it.pos_z          = pick_coord();
      it.heading        = pick_heading();
      it.offset_right   = pick_coord();
      it.offset_up      = pick_coord();
      it.offset_forward = pick_coord();
      send_move(it, shift_position(it));
    end
    calm = 1'b0;
    item_valid <= 1'b0;
    while (landing_q.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (fault_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // Check each accepted result against the oldest prediction; stall at random
  always @(posedge clk) begin : sink
    result_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (landing_q.size() == 0) begin
        flag_fault($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = landing_q.pop_front();
        if (result.new_x !== want.new_x)
          flag_fault($sformatf("result %0d new_x got %0d want %0d", results_seen,
                               $signed(result.new_x), $signed(want.new_x)));
        if (result.new_y !== want.new_y)
          flag_fault($sformatf("result %0d new_y got %0d want %0d", results_seen,
                               $signed(result.new_y), $signed(want.new_y)));
        if (result.new_z !== want.new_z)
          flag_fault($sformatf("result %0d new_z got %0d want %0d", results_seen,
                               $signed(result.new_z), $signed(want.new_z)));
        if (result.saturated !== want.saturated)
          flag_fault($sformatf("result %0d saturated got %b want %b", results_seen,
                               result.saturated, want.saturated));
      end
    end
    result_ready <= ($urandom_range(99) >= (calm ? 0 : IDLE_PCT));
  end

  // End the run when neither side moves an item for too long
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

endmodule
